// ===== hw/rtl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Shared codes, state type and controller/datapath bundles for the
// linear probing hash set.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int KEY_W   = 64;
  localparam int ACT_W   = 2;
  localparam int SLOT_W  = 10;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 4;
  localparam int BITS_W  = 5;

  localparam logic [CFG_W-1:0]  INDEX_BITS_RESET = 4'd10;
  localparam logic [BITS_W-1:0] MIN_BITS         = 5'd2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CHECK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_MISC
  } lph_state_t;

  typedef struct packed {
    logic              load;
    logic              clear;
    logic              read;
    logic              step;
    logic              write_key;
    logic              write_del;
    logic              finish;
    logic [STAT_W-1:0] fin_status;
    logic              fin_slot;
  } lph_cmd_t;

  typedef struct packed {
    logic             clr_last;
    logic             is_empty;
    logic             is_match;
    logic             is_last;
    logic [ACT_W-1:0] act;
  } lph_stat_t;

endpackage

// ===== hw/rtl/lph_ctrl.sv =====
// ----------------------------------------------------------------------------
// lph_ctrl
// Sequencer for the hash set: clearing pass, probe loop and result issue.
// ----------------------------------------------------------------------------
module lph_ctrl
  import lph_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [ACT_W-1:0] action,
  input  lph_stat_t stat,
  output lph_cmd_t  cmd,
  output logic      busy
);

  lph_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (action == ACT_INSERT || action == ACT_CHECK) begin
            state_next = S_READ;
          end else begin
            state_next = S_MISC;
          end
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.is_empty || stat.is_match || stat.is_last) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_READ;
        end
      end
      S_MISC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
      end
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_READ: begin
        cmd.read = 1'b1;
      end
      S_CMP: begin
        if (stat.is_empty) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          cmd.fin_slot   = (stat.act == ACT_INSERT);
          cmd.write_key  = (stat.act == ACT_INSERT);
        end else if (stat.is_match) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_PRESENT;
        end else if (stat.is_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_FULL;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_MISC: begin
        cmd.finish     = 1'b1;
        cmd.fin_status = ST_OK;
        cmd.write_del  = (stat.act == ACT_DELETE);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/lph_datapath.sv =====
// ----------------------------------------------------------------------------
// lph_datapath
// Key store, probe index and counter, index_bits register and result word.
// ----------------------------------------------------------------------------
module lph_datapath
  import lph_pkg::*;
#(
  parameter int TABLE_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  lph_cmd_t          cmd,
  output lph_stat_t         stat,
  input  logic [ACT_W-1:0]  action,
  input  logic [KEY_W-1:0]  key,
  input  logic [SLOT_W-1:0] slot,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              done,
  output logic [STAT_W-1:0] status,
  output logic [SLOT_W-1:0] slot_used
);

  localparam int AW    = TABLE_BITS;
  localparam int DEPTH = 1 << AW;

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rdata;

  logic [CFG_W-1:0]  index_bits;
  logic [ACT_W-1:0]  act;
  logic [KEY_W-1:0]  key_q;
  logic [SLOT_W-1:0] slot_q;
  logic [AW-1:0]     idx;
  logic [AW:0]       cnt;
  logic [AW-1:0]     clr_addr;

  logic [BITS_W-1:0] bits;
  logic [AW-1:0]     mask;
  logic [AW:0]       size;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [KEY_W-1:0]  wdata;

  // clamp index_bits to the range of the table
  always_comb begin
    bits = {1'b0, index_bits};
    if (bits < MIN_BITS) begin
      bits = MIN_BITS;
    end else if (bits > BITS_W'(TABLE_BITS)) begin
      bits = BITS_W'(TABLE_BITS);
    end
    for (int i = 0; i < AW; i++) begin
      mask[i] = (BITS_W'(i) < bits);
    end
    size = {1'b0, mask} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= INDEX_BITS_RESET;
    end else if (cfg_we) begin
      index_bits <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= action;
      key_q  <= key;
      slot_q <= slot;
      idx    <= key[AW-1:0] & mask;
      cnt    <= '0;
    end else if (cmd.step) begin
      idx <= (idx + 1'b1) & mask;
      cnt <= cnt + 1'b1;
    end
  end

  // single write port shared by clearing, insert and delete
  always_comb begin
    we    = cmd.clear | cmd.write_key | cmd.write_del;
    waddr = idx;
    wdata = key_q;
    if (cmd.clear) begin
      waddr = clr_addr;
      wdata = '0;
    end else if (cmd.write_del) begin
      waddr = AW'(slot_q) & mask;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.read) begin
      rdata <= mem[idx];
    end
  end

  always_comb begin
    stat.clr_last = &clr_addr;
    stat.is_empty = (rdata == '0);
    stat.is_match = (rdata == key_q);
    stat.is_last  = ((cnt + 1'b1) == size);
    stat.act      = act;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status    <= cmd.fin_status;
      slot_used <= cmd.fin_slot ? SLOT_W'(idx) : '0;
    end
  end

endmodule

// ===== hw/rtl/linear_probe_hash_set.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Linear probing set of 64-bit keys with insert, check and delete by slot.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Insert and check hold
// busy while they probe, each slot probed passing through a registered table
// read and a compare; delete and the unused action skip it. The result appears
// with done for one cycle, the cycle after the probe ends, and must be taken
// then: there is no back-pressure on the result side. After reset the table
// is cleared one slot a cycle, all 2**TABLE_BITS slots, with busy held high;
// index_bits writes are accepted at any time, cfg_ready is always high.
module linear_probe_hash_set
  import lph_pkg::*;
#(
  parameter int TABLE_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action,
  input  logic [KEY_W-1:0]  key,
  input  logic [SLOT_W-1:0] slot,
  output logic              done,
  output logic [STAT_W-1:0] status,
  output logic [SLOT_W-1:0] slot_used,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  lph_cmd_t  cmd;
  lph_stat_t stat;

  assign cfg_ready = 1'b1;

  lph_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  lph_datapath #(
    .TABLE_BITS (TABLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .action    (action),
    .key       (key),
    .slot      (slot),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .status    (status),
    .slot_used (slot_used)
  );

endmodule
